@@ sv/lsp_pkg.sv @@
package lsp_pkg;

  // Default byte limit for one load option
  localparam int unsigned MAX_BLOB_BYTES_DEF = 16384;

  // Result queue depth; the parser may push two words in one cycle
  localparam int unsigned QDEPTH = 4;

  // Result kinds
  localparam logic [1:0] KIND_DESC    = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Summary status codes
  localparam logic [1:0] STATUS_INVALID = 2'd0;
  localparam logic [1:0] STATUS_VALID   = 2'd1;
  localparam logic [1:0] STATUS_DISK    = 2'd2;

  // Device path codes
  localparam logic [7:0]  NODE_MEDIA    = 8'h04;
  localparam logic [7:0]  SUB_HARDDRIVE = 8'h01;
  localparam logic [7:0]  SUB_FILEPATH  = 8'h04;
  localparam logic [7:0]  NODE_END      = 8'h7F;
  localparam logic [7:0]  SIG_GUID      = 8'h02;
  localparam logic [15:0] HD_NODE_LEN   = 16'd42;
  localparam logic [15:0] MIN_NODE_LEN  = 16'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] code_unit;
    logic        last_of_run;
    logic [1:0]  status;
    logic [31:0] attributes;
    logic [31:0] partition_number;
    logic [63:0] partition_start;
    logic [63:0] partition_size;
    logic [7:0]  mbr_kind;
    logic [7:0]  signature_kind;
    logic [63:0] guid_low;
    logic [63:0] guid_high;
  } result_t;

endpackage

@@ sv/lsp_parser.sv @@
module lsp_parser import lsp_pkg::*; #(
  parameter int unsigned MAX_BLOB_BYTES = MAX_BLOB_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] res_cnt
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DESC   = 2'd1;
  localparam logic [1:0] PH_PATH   = 2'd2;
  localparam logic [15:0] MAX_POS  = 16'(MAX_BLOB_BYTES);

  typedef struct packed {
    logic stop;
    logic disk;
    logic fpdone;
    logic nul;
    logic over;
    logic hdnode;
    logic fpnode;
  } flags_t;

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] poff_r, poff_nxt;
  logic [15:0] nstart_r, nstart_nxt;
  flags_t      fl_r, fl_nxt;

  logic [31:0] attr_r, attr_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic [7:0]  nkind_r, nkind_nxt;
  logic [7:0]  nsub_r, nsub_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [31:0] pnum_r, pnum_nxt;
  logic [63:0] pstart_r, pstart_nxt;
  logic [63:0] psize_r, psize_nxt;
  logic [63:0] glow_r, glow_nxt;
  logic [63:0] ghigh_r, ghigh_nxt;
  logic [7:0]  mbr_r, mbr_nxt;
  logic [7:0]  sig_r, sig_nxt;

  logic [15:0] rel;
  logic [15:0] len_full;
  logic [16:0] node_end_sum;
  logic [15:0] unit_word;
  logic        unit_vld;
  logic [1:0]  unit_kind;
  logic        node_end;
  logic        ok;
  result_t     unit_res;
  result_t     sum_res;

  assign rel          = poff_r - nstart_r;
  assign len_full     = {data_byte, nlen_r[7:0]};
  assign node_end_sum = {1'b0, nstart_r} + {1'b0, len_full};
  assign unit_word    = {data_byte, held_r};

  // Parse one byte against the current state
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    poff_nxt   = poff_r;
    nstart_nxt = nstart_r;
    fl_nxt     = fl_r;
    attr_nxt   = attr_r;
    plen_nxt   = plen_r;
    nlen_nxt   = nlen_r;
    nkind_nxt  = nkind_r;
    nsub_nxt   = nsub_r;
    held_nxt   = held_r;
    pnum_nxt   = pnum_r;
    pstart_nxt = pstart_r;
    psize_nxt  = psize_r;
    glow_nxt   = glow_r;
    ghigh_nxt  = ghigh_r;
    mbr_nxt    = mbr_r;
    sig_nxt    = sig_r;
    unit_vld   = 1'b0;
    unit_kind  = KIND_DESC;
    node_end   = 1'b0;
    ok         = 1'b0;
    unit_res   = '0;
    sum_res    = '0;
    res0       = '0;
    res1       = '0;
    res_cnt    = 2'd0;

    if (step) begin
      if (pos_r >= MAX_POS) begin
        fl_nxt.over = 1'b1;
      end else begin
        pos_nxt = pos_r + 16'd1;
        case (phase_r)
          PH_HEADER: begin
            if (pos_r[15:2] == 14'd0) begin
              attr_nxt[{pos_r[1:0], 3'b000} +: 8] = data_byte;
            end else if (pos_r[2:0] == 3'd4) begin
              plen_nxt[7:0] = data_byte;
            end else begin
              plen_nxt[15:8] = data_byte;
              phase_nxt      = PH_DESC;
            end
          end
          PH_DESC: begin
            if (!pos_r[0]) begin
              held_nxt = data_byte;
            end else if (unit_word == 16'd0) begin
              phase_nxt = PH_PATH;
            end else begin
              unit_vld  = 1'b1;
              unit_kind = KIND_DESC;
            end
          end
          PH_PATH: begin
            if (poff_r < plen_r) begin
              poff_nxt = poff_r + 16'd1;
              if (!fl_r.stop) begin
                if (rel == 16'd0) begin
                  nkind_nxt = data_byte;
                end else if (rel == 16'd1) begin
                  nsub_nxt = data_byte;
                end else if (rel == 16'd2) begin
                  nlen_nxt = {8'h00, data_byte};
                end else if (rel == 16'd3) begin
                  nlen_nxt = len_full;
                  // Stop the walk on a bad or terminating node
                  if (len_full < MIN_NODE_LEN || node_end_sum > {1'b0, plen_r} ||
                      nkind_r == NODE_END) begin
                    fl_nxt.stop = 1'b1;
                  end else begin
                    fl_nxt.hdnode = nkind_r == NODE_MEDIA && nsub_r == SUB_HARDDRIVE &&
                                    len_full == HD_NODE_LEN && !fl_r.disk;
                    fl_nxt.fpnode = nkind_r == NODE_MEDIA && nsub_r == SUB_FILEPATH &&
                                    !fl_r.fpdone;
                    fl_nxt.nul    = 1'b0;
                    node_end      = len_full == MIN_NODE_LEN;
                  end
                end else begin
                  // Capture the hard-drive node body
                  if (fl_r.hdnode) begin
                    if (rel[15:2] == 14'd1) begin
                      pnum_nxt[{rel[1:0], 3'b000} +: 8] = data_byte;
                    end else if (rel[15:6] == 10'd0) begin
                      case (rel[5:3])
                        3'd1: pstart_nxt[{rel[2:0], 3'b000} +: 8] = data_byte;
                        3'd2: psize_nxt[{rel[2:0], 3'b000} +: 8]  = data_byte;
                        3'd3: glow_nxt[{rel[2:0], 3'b000} +: 8]   = data_byte;
                        3'd4: ghigh_nxt[{rel[2:0], 3'b000} +: 8]  = data_byte;
                        default: ;
                      endcase
                    end
                    if (rel == 16'd40) begin
                      mbr_nxt = data_byte;
                    end
                    if (rel == 16'd41) begin
                      sig_nxt     = data_byte;
                      fl_nxt.disk = 1'b1;
                    end
                  end
                  // Pair file path bytes into units
                  if (fl_r.fpnode && !fl_r.nul) begin
                    if (!rel[0]) begin
                      held_nxt = data_byte;
                    end else if (unit_word == 16'd0) begin
                      fl_nxt.nul = 1'b1;
                    end else begin
                      unit_vld      = 1'b1;
                      unit_kind     = KIND_PATH;
                      fl_nxt.fpdone = 1'b1;
                    end
                  end
                  node_end = ({1'b0, rel} + 17'd1) == {1'b0, nlen_r};
                end
                // Advance to the next node
                if (node_end) begin
                  nstart_nxt    = nstart_r + nlen_nxt;
                  fl_nxt.hdnode = 1'b0;
                  fl_nxt.fpnode = 1'b0;
                  fl_nxt.nul    = 1'b0;
                end
              end
            end
          end
          default: ;
        endcase
      end

      unit_res.kind      = unit_kind;
      unit_res.code_unit = unit_word;

      // Build the summary from the updated state
      sum_res.kind = KIND_SUMMARY;
      if (phase_nxt != PH_HEADER) begin
        sum_res.attributes = attr_nxt;
      end
      ok = !fl_nxt.over && phase_nxt == PH_PATH && poff_nxt == plen_nxt;
      if (ok) begin
        sum_res.status = STATUS_VALID;
        if (fl_nxt.disk) begin
          sum_res.status           = STATUS_DISK;
          sum_res.partition_number = pnum_nxt;
          sum_res.partition_start  = pstart_nxt;
          sum_res.partition_size   = psize_nxt;
          sum_res.mbr_kind         = mbr_nxt;
          sum_res.signature_kind   = sig_nxt;
          if (sig_nxt == SIG_GUID) begin
            sum_res.guid_low  = glow_nxt;
            sum_res.guid_high = ghigh_nxt;
          end
        end
      end
      sum_res.last_of_run = 1'b1;

      if (last_byte) begin
        // Return to the idle state for the next blob
        phase_nxt  = PH_HEADER;
        pos_nxt    = 16'd0;
        poff_nxt   = 16'd0;
        nstart_nxt = 16'd0;
        fl_nxt     = '0;
        if (unit_vld) begin
          res0    = unit_res;
          res1    = sum_res;
          res_cnt = 2'd2;
        end else begin
          res0    = sum_res;
          res_cnt = 2'd1;
        end
      end else if (unit_vld) begin
        res0             = unit_res;
        res0.last_of_run = 1'b1;
        res_cnt          = 2'd1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      pos_r    <= '0;
      poff_r   <= '0;
      nstart_r <= '0;
      fl_r     <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      poff_r   <= poff_nxt;
      nstart_r <= nstart_nxt;
      fl_r     <= fl_nxt;
    end
  end

  // Field capture registers
  always_ff @(posedge clk) begin
    attr_r   <= attr_nxt;
    plen_r   <= plen_nxt;
    nlen_r   <= nlen_nxt;
    nkind_r  <= nkind_nxt;
    nsub_r   <= nsub_nxt;
    held_r   <= held_nxt;
    pnum_r   <= pnum_nxt;
    pstart_r <= pstart_nxt;
    psize_r  <= psize_nxt;
    glow_r   <= glow_nxt;
    ghigh_r  <= ghigh_nxt;
    mbr_r    <= mbr_nxt;
    sig_r    <= sig_nxt;
  end

endmodule

@@ sv/lsp_result_fifo.sv @@
module lsp_result_fifo import lsp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  result_t                      push0,
  input  result_t                      push1,
  input  logic [1:0]                   push_cnt,
  input  logic                         pop,
  output result_t                      head,
  output logic                         not_empty,
  output logic [$clog2(QDEPTH+1)-1:0]  count
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  result_t       mem_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + PW'(1);
  assign head      = mem_r[rd_ptr_r];
  assign not_empty = cnt_r != '0;
  assign count     = cnt_r;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store up to two words per cycle
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

@@ sv/load_option_stream_parser_core.sv @@
// Load option stream parser.
// Input channel: one blob byte per word (in_data_byte), with in_last_byte on
// the final byte. Output channel: one result per word, kind 0 description
// unit, kind 1 file path unit, kind 2 entry summary; out_last_of_run marks
// the final result caused by one input byte (at most two per byte).
// Both channels use valid/stall; a word moves when valid is high and stall
// is low.
// An accepted byte is held in the input register, parsed when the queue has
// room for two words, and its results are written to the queue and offered.
// Throughput: one byte per cycle, set by the single-pass parse logic between
// the input register and the four-word result queue; a byte waits in the
// input register while the queue holds more than two words.
// Reset: rst_n low at a clock edge empties the input register and the queue
// and returns the parser to the start of a blob. After a summary the parser
// is back at the start of a blob as well.
// When the receiver stalls, results collect in the queue and input stall
// rises once the queue cannot take two more words.
module load_option_stream_parser_core import lsp_pkg::*; #(
  parameter int unsigned MAX_BLOB_BYTES = MAX_BLOB_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_code_unit,
  output logic        out_last_of_run,
  output logic [1:0]  out_status,
  output logic [31:0] out_attributes,
  output logic [31:0] out_partition_number,
  output logic [63:0] out_partition_start,
  output logic [63:0] out_partition_size,
  output logic [7:0]  out_mbr_kind,
  output logic [7:0]  out_signature_kind,
  output logic [63:0] out_guid_low,
  output logic [63:0] out_guid_high
);

  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic          in_vld_r;
  logic [7:0]    in_byte_r;
  logic          in_last_r;
  logic          consume;
  logic          pop;
  result_t       res0;
  result_t       res1;
  logic [1:0]    res_cnt;
  result_t       head;
  logic          not_empty;
  logic [CW-1:0] fifo_cnt;

  // Parse the held byte only when the queue has room for two words
  assign consume  = in_vld_r && (fifo_cnt <= CW'(QDEPTH - 2));
  assign in_stall = in_vld_r && !consume;
  assign pop      = not_empty && !out_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  lsp_parser #(
    .MAX_BLOB_BYTES(MAX_BLOB_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (consume),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .res0      (res0),
    .res1      (res1),
    .res_cnt   (res_cnt)
  );

  lsp_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0),
    .push1     (res1),
    .push_cnt  (res_cnt),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (fifo_cnt)
  );

  // Drive the result word from the queue head
  assign out_valid            = not_empty;
  assign out_kind             = head.kind;
  assign out_code_unit        = head.code_unit;
  assign out_last_of_run      = head.last_of_run;
  assign out_status           = head.status;
  assign out_attributes       = head.attributes;
  assign out_partition_number = head.partition_number;
  assign out_partition_start  = head.partition_start;
  assign out_partition_size   = head.partition_size;
  assign out_mbr_kind         = head.mbr_kind;
  assign out_signature_kind   = head.signature_kind;
  assign out_guid_low         = head.guid_low;
  assign out_guid_high        = head.guid_high;

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= CW'(QDEPTH))
    else $error("result queue overflow");

  a_pair_ends_summary: assert property (@(posedge clk) disable iff (!rst_n)
    consume && res_cnt == 2'd2 |-> res1.kind == KIND_SUMMARY && res0.kind != KIND_SUMMARY)
    else $error("second result of a byte is not a summary");

  a_summary_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> out_last_of_run)
    else $error("summary without last_of_run");

  a_unit_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SUMMARY |-> out_status == STATUS_INVALID)
    else $error("unit result carries a status");

  a_last_pushes_summary: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_last_r |-> res_cnt != 2'd0)
    else $error("final byte produced no summary");
`endif

endmodule
